>>> rtl/pllr_pkg.sv
// Shared constants, status codes and helpers for the Poisson LLR accumulator.
package pllr_pkg;

    localparam int IN_N_W   = 16;
    localparam int IN_Q_W   = 24;
    localparam int OUT_W    = 48;
    localparam int LOGX_W   = IN_Q_W + 1;     // b + s fits here
    localparam int MANT_W   = 32;             // Q1.31 mantissa
    localparam int EXP_W    = 5;
    localparam int LOG_W    = EXP_W + 32;     // integer part . 32 fraction bits
    localparam int LNQ_W    = 37;
    localparam int PROD_W   = LNQ_W + IN_N_W;
    localparam int ACC_W    = 66;

    localparam int DEF_FRAC_BITS = 16;
    localparam int DEF_SUM_WIDTH = 48;

    localparam logic [31:0] LN2_Q32 = 32'd2977044472;

    localparam logic [1:0] ST_FINITE = 2'd0;
    localparam logic [1:0] ST_NEGINF = 2'd1;
    localparam logic [1:0] ST_NAN    = 2'd2;
    localparam logic [1:0] ST_SAT    = 2'd3;

    function automatic logic [1:0] status_rank(input logic [1:0] st);
        logic [1:0] r;
        begin
            unique case (st)
                ST_NAN:    r = 2'd3;
                ST_NEGINF: r = 2'd2;
                ST_SAT:    r = 2'd1;
                default:   r = 2'd0;
            endcase
            return r;
        end
    endfunction

    function automatic logic [1:0] status_merge(input logic [1:0] old_st,
                                                input logic [1:0] ev);
        begin
            return (status_rank(ev) > status_rank(old_st)) ? ev : old_st;
        end
    endfunction

endpackage

>>> rtl/pllr_log2.sv
// Bit-serial log2 unit: one fraction bit per cycle by repeated squaring.
module pllr_log2
    import pllr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [LOGX_W-1:0] x,
    output logic              done,
    output logic [LOG_W-1:0]  result
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [4:0]        cnt_reg, cnt_next;
    logic [MANT_W-1:0] m_reg, m_next;
    logic [31:0]       frac_reg, frac_next;
    logic [EXP_W-1:0]  p_reg, p_next;
    logic [EXP_W-1:0]  lead;
    logic [63:0]       sq;
    logic [32:0]       sq_top;

    always_comb
    begin
        lead = '0;
        for (int i = 0; i < LOGX_W; i++)
        begin
            if (x[i])
            begin
                lead = EXP_W'(i);
            end
        end
    end

    assign sq     = 64'(m_reg) * 64'(m_reg);
    assign sq_top = sq[63:31];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        m_next    = m_reg;
        frac_next = frac_reg;
        p_next    = p_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            p_next    = lead;
            m_next    = MANT_W'(x) << (5'd31 - lead);
            frac_next = '0;
        end
        else if (busy_reg)
        begin
            // square reaching 2 gives a one digit and is halved
            if (sq_top[32])
            begin
                m_next    = sq_top[32:1];
                frac_next = {frac_reg[30:0], 1'b1};
            end
            else
            begin
                m_next    = sq_top[31:0];
                frac_next = {frac_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg    <= m_next;
        frac_reg <= frac_next;
        p_reg    <= p_next;
    end

    assign done   = done_reg;
    assign result = {p_reg, frac_reg};

endmodule

>>> rtl/poisson_llr_accumulator_core.sv
// Binned Poisson log-likelihood-ratio accumulator, top level.
//
// Input channel (in_valid/in_stall): one histogram bin per transfer, with
// count n, background b and signal s in unsigned fixed point, and last_bin.
// Output channel (out_valid/out_stall): one transfer per last bin, carrying
// twice the accumulated sum and a status (finite, minus infinity, not a
// number, saturated).
// One bin is processed at a time. A bin that needs the logarithm passes,
// after the accepting cycle, through two parallel bit-serial log2 units
// (one fraction bit per cycle), then the ln2 scaling, the bit-serial
// multiply by n, the term and the accumulate. A bin with n = 0, s = 0 or
// b = 0 goes from acceptance straight to the accumulate. A last bin adds
// a step to load the output register.
// The output register holds a result until taken; the next bin is accepted
// meanwhile, and only a following last bin waits on a stalled output.
// Reset clears the sum, the sticky status and the output valid.
module poisson_llr_accumulator_core
    import pllr_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS,
    parameter int SUM_WIDTH = DEF_SUM_WIDTH
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [IN_N_W-1:0]        observed_count,
    input  logic [IN_Q_W-1:0]        background_expect,
    input  logic [IN_Q_W-1:0]        signal_expect,
    input  logic                     last_bin,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [OUT_W-1:0]  statistic,
    output logic [1:0]               status
);

    localparam int SH = 32 - FRAC_BITS;
    localparam logic [PROD_W:0] ROUND_C = (PROD_W + 1)'(1) << (SH - 1);
    localparam logic signed [ACC_W-1:0] SUM_MAX =
        (ACC_W'(1) << (SUM_WIDTH - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] SUM_MIN = ~SUM_MAX;
    localparam logic signed [ACC_W-1:0] HALF_MAX = (ACC_W'(1) << (OUT_W - 2)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] HALF_MIN = ~HALF_MAX;
    localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W - 1){1'b1}}};
    localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W - 1){1'b0}}};

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOG  = 3'd1;
    localparam logic [2:0] S_LN   = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_TERM = 3'd4;
    localparam logic [2:0] S_ACC  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0]               state_reg, state_next;
    logic [IN_N_W-1:0]        mplier_reg, mplier_next;
    logic [IN_Q_W-1:0]        s_reg, s_next;
    logic                     last_reg, last_next;
    logic                     add_en_reg, add_en_next;
    logic [1:0]               ev_reg, ev_next;
    logic [LOG_W-1:0]         d_reg, d_next;
    logic [PROD_W-1:0]        mcand_reg, mcand_next;
    logic [PROD_W-1:0]        prod_reg, prod_next;
    logic [3:0]               cnt_reg, cnt_next;
    logic signed [ACC_W-1:0]  term_reg, term_next;
    logic signed [SUM_WIDTH-1:0] sum_reg, sum_next;
    logic [1:0]               sticky_reg, sticky_next;
    logic                     out_valid_reg, out_valid_next;
    logic signed [OUT_W-1:0]  stat_reg, stat_next;
    logic [1:0]               ost_reg, ost_next;

    logic                     in_xfer;
    logic                     special;
    logic                     log_start;
    logic                     hi_done, lo_done;
    logic [LOG_W-1:0]         hi_res, lo_res;
    logic [63:0]              frac_prod;
    logic [PROD_W:0]          rnd_sum;
    logic signed [ACC_W-1:0]  sum_ext;
    logic signed [ACC_W-1:0]  sum_add;
    logic                     out_free;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign special   = (background_expect == '0) && (observed_count != '0);
    assign log_start = in_xfer && !special && (observed_count != '0)
                       && (signal_expect != '0);

    pllr_log2 u_log_hi
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (log_start),
        .x      (LOGX_W'(background_expect) + LOGX_W'(signal_expect)),
        .done   (hi_done),
        .result (hi_res)
    );

    pllr_log2 u_log_lo
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (log_start),
        .x      (LOGX_W'(background_expect)),
        .done   (lo_done),
        .result (lo_res)
    );

    assign frac_prod = 64'(d_reg[31:0]) * 64'(LN2_Q32);
    assign rnd_sum   = {1'b0, prod_reg} + ROUND_C;
    assign sum_ext   = ACC_W'(sum_reg);
    assign sum_add   = sum_ext + term_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        mplier_next    = mplier_reg;
        s_next         = s_reg;
        last_next      = last_reg;
        add_en_next    = add_en_reg;
        ev_next        = ev_reg;
        d_next         = d_reg;
        mcand_next     = mcand_reg;
        prod_next      = prod_reg;
        cnt_next       = cnt_reg;
        term_next      = term_reg;
        sum_next       = sum_reg;
        sticky_next    = sticky_reg;
        out_valid_next = out_valid_reg && out_stall;
        stat_next      = stat_reg;
        ost_next       = ost_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    mplier_next = observed_count;
                    s_next      = signal_expect;
                    last_next   = last_bin;
                    add_en_next = !special;
                    ev_next     = special ? ((signal_expect == '0) ? ST_NAN : ST_NEGINF)
                                          : ST_FINITE;
                    term_next   = ACC_W'(signal_expect);
                    state_next  = log_start ? S_LOG : S_ACC;
                end
            end
            S_LOG:
            begin
                if (hi_done && lo_done)
                begin
                    d_next     = hi_res - lo_res;
                    state_next = S_LN;
                end
            end
            S_LN:
            begin
                mcand_next = PROD_W'(LNQ_W'(64'(d_reg[LOG_W-1:32]) * 64'(LN2_Q32))
                                     + LNQ_W'(frac_prod[63:32]));
                prod_next  = '0;
                cnt_next   = '0;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                // n taken one bit per cycle, LSB first
                if (mplier_reg[0])
                begin
                    prod_next = prod_reg + mcand_reg;
                end
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                cnt_next    = cnt_reg + 4'd1;
                if (cnt_reg == 4'd15)
                begin
                    state_next = S_TERM;
                end
            end
            S_TERM:
            begin
                term_next  = ACC_W'(s_reg) - ACC_W'(rnd_sum >> SH);
                state_next = S_ACC;
            end
            S_ACC:
            begin
                if (add_en_reg)
                begin
                    if (sum_add > SUM_MAX)
                    begin
                        sum_next    = SUM_WIDTH'(SUM_MAX);
                        sticky_next = status_merge(sticky_reg, ST_SAT);
                    end
                    else if (sum_add < SUM_MIN)
                    begin
                        sum_next    = SUM_WIDTH'(SUM_MIN);
                        sticky_next = status_merge(sticky_reg, ST_SAT);
                    end
                    else
                    begin
                        sum_next = SUM_WIDTH'(sum_add);
                    end
                end
                else
                begin
                    sticky_next = status_merge(sticky_reg, ev_reg);
                end
                state_next = last_reg ? S_OUT : S_IDLE;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    ost_next       = sticky_reg;
                    if (sticky_reg == ST_NEGINF)
                    begin
                        stat_next = OUT_MIN;
                    end
                    else if (sticky_reg == ST_NAN)
                    begin
                        stat_next = '0;
                    end
                    else if (sum_ext > HALF_MAX)
                    begin
                        stat_next = OUT_MAX;
                        ost_next  = ST_SAT;
                    end
                    else if (sum_ext < HALF_MIN)
                    begin
                        stat_next = OUT_MIN;
                        ost_next  = ST_SAT;
                    end
                    else
                    begin
                        stat_next = OUT_W'(sum_ext <<< 1);
                    end
                    sum_next    = '0;
                    sticky_next = ST_FINITE;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sum_reg       <= '0;
            sticky_reg    <= ST_FINITE;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            sticky_reg    <= sticky_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mplier_reg <= mplier_next;
        s_reg      <= s_next;
        last_reg   <= last_next;
        add_en_reg <= add_en_next;
        ev_reg     <= ev_next;
        d_reg      <= d_next;
        mcand_reg  <= mcand_next;
        prod_reg   <= prod_next;
        term_reg   <= term_next;
        stat_reg   <= stat_next;
        ost_reg    <= ost_next;
    end

    assign out_valid = out_valid_reg;
    assign statistic = stat_reg;
    assign status    = ost_reg;

`ifndef SYNTHESIS
    a_out_from_final: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result loaded outside the final step");

    a_clear_after_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> (sum_reg == '0) && (sticky_reg == ST_FINITE))
        else $error("sum not cleared after a result");

    a_logs_in_step: assert property (@(posedge clk) disable iff (!rst_n)
        hi_done == lo_done)
        else $error("log2 units out of step");

    a_nan_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_NAN) |-> statistic == '0)
        else $error("not-a-number result with nonzero statistic");
`endif

endmodule
